FILE: rtl/core/assert_macros.svh
// assertion macros shared by the scaler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every clock edge out of reset
`define SCJS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("scaler assertion failed");
// same-cycle implication
`define SCJS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scaler assertion failed");
`else
`define SCJS_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define SCJS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/scjs_pkg.sv
// types and constants shared by the joystick scaler
package scjs_pkg;

    localparam int RAW_W     = 16;               // raw axis field width
    localparam int SPAN_W    = RAW_W + 1;        // max - min width
    localparam int RNG_W     = 17;               // range = high - low + 1
    localparam int VAL_W     = 16;               // scaled axis width
    localparam int NUM_W     = RAW_W + RNG_W;    // product width
    localparam int QUO_W     = 17;               // quotient never exceeds range
    localparam int DIV_CNT_W = 5;                // holds QUO_W
    localparam int AXES      = 4;
    localparam int AX_W      = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [AX_W-1:0] AX_LAST = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 1'b1;

    localparam logic signed [VAL_W-1:0] DEF_LOW  = -16'sd1;
    localparam logic signed [VAL_W-1:0] DEF_HIGH = 16'sd1;

    localparam int BTN_FIRE_LSB = 4;

    typedef struct packed {
        logic [RAW_W-1:0] stick1_x_raw;
        logic [RAW_W-1:0] stick1_y_raw;
        logic [RAW_W-1:0] stick2_x_raw;
        logic [RAW_W-1:0] stick2_y_raw;
        logic [7:0]       button_bits;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] stick1_x;
        logic signed [VAL_W-1:0] stick1_y;
        logic signed [VAL_W-1:0] stick2_x;
        logic signed [VAL_W-1:0] stick2_y;
        logic                    stick1_fire_a;
        logic                    stick1_fire_b;
        logic                    stick2_fire_a;
        logic                    stick2_fire_b;
    } t_out;

    // one classified reading, waiting for the scaling unit
    typedef struct packed {
        logic [AXES-1:0][RAW_W-1:0]  diff;    // raw - min
        logic [AXES-1:0][SPAN_W-1:0] span;    // max - min
        logic [AXES-1:0]             bad;     // no positive span
        logic [1:0]                  absent;  // per stick
        logic signed [VAL_W-1:0]     low;
        logic signed [VAL_W-1:0]     high;
        logic signed [VAL_W-1:0]     mid;
        logic [RNG_W-1:0]            rng;
        logic [3:0]                  fire;
    } t_job;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [SPAN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

    typedef enum logic [2:0] {
        BE_IDLE,
        BE_MUL,
        BE_START,
        BE_DIV,
        BE_OUT
    } t_be_state;

endpackage

FILE: rtl/core/scjs_fe.sv
// front end: config registers, min/max tracking and job building
`include "assert_macros.svh"
module scjs_fe #(
    parameter int AXIS_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [scjs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [scjs_pkg::VAL_W-1:0]          i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  scjs_pkg::t_in                       i_in_data,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output scjs_pkg::t_job                      o_q_job
);
    localparam int AW  = AXIS_BITS;
    localparam int RW  = scjs_pkg::RAW_W;
    localparam int SW  = scjs_pkg::SPAN_W;
    localparam int VW  = scjs_pkg::VAL_W;
    localparam int GW  = scjs_pkg::RNG_W;
    localparam int NAX = scjs_pkg::AXES;
    localparam int BL  = scjs_pkg::BTN_FIRE_LSB;

    logic [NAX-1:0][AW-1:0] r_min;
    logic [NAX-1:0][AW-1:0] n_min;
    logic [NAX-1:0][AW:0]   r_max;
    logic [NAX-1:0][AW:0]   n_max;
    logic signed [VW-1:0]   r_low;
    logic signed [VW-1:0]   r_high;

    logic [NAX-1:0][AW-1:0] raw;
    logic [NAX-1:0][AW:0]   max_seed;
    logic [NAX-1:0][AW-1:0] diff;
    logic [NAX-1:0][AW:0]   span;
    logic signed [VW-1:0]   eff_low;
    logic signed [VW-1:0]   eff_high;
    logic [VW+1:0]          rng_w;
    logic signed [VW+1:0]   mid_w;
    logic signed [VW+1:0]   high_ext;
    logic signed [VW-1:0]   mid_clip;
    logic                   accept;

    assign raw[0] = i_in_data.stick1_x_raw[AW-1:0];
    assign raw[1] = i_in_data.stick1_y_raw[AW-1:0];
    assign raw[2] = i_in_data.stick2_x_raw[AW-1:0];
    assign raw[3] = i_in_data.stick2_y_raw[AW-1:0];

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_q_push   = accept;

    // min first, seed an untouched max from it, then max
    always_comb begin
        for (int i = 0; i < NAX; i++) begin
            n_min[i]    = (raw[i] < r_min[i]) ? raw[i] : r_min[i];
            max_seed[i] = (r_max[i] == '0) ? ({1'b0, n_min[i]} + 1'b1) : r_max[i];
            n_max[i]    = ({1'b0, raw[i]} > max_seed[i]) ? {1'b0, raw[i]} : max_seed[i];
            diff[i]     = raw[i] - n_min[i];
            span[i]     = n_max[i] - {1'b0, n_min[i]};
        end
    end

    // effective range, fallback when low is not below high
    always_comb begin
        if (r_low >= r_high) begin
            eff_low  = scjs_pkg::DEF_LOW;
            eff_high = scjs_pkg::DEF_HIGH;
        end else begin
            eff_low  = r_low;
            eff_high = r_high;
        end
        rng_w    = {eff_high[VW-1], eff_high[VW-1], eff_high}
                 - {eff_low[VW-1], eff_low[VW-1], eff_low} + 1'b1;
        mid_w    = {eff_low[VW-1], eff_low[VW-1], eff_low} + {1'b0, rng_w[VW+1:1]};
        high_ext = {eff_high[VW-1], eff_high[VW-1], eff_high};
        mid_clip = (mid_w > high_ext) ? eff_high : mid_w[VW-1:0];
    end

    always_comb begin
        for (int i = 0; i < NAX; i++) begin
            o_q_job.diff[i] = RW'(diff[i]);
            o_q_job.span[i] = SW'(span[i]);
            o_q_job.bad[i]  = (n_max[i] <= {1'b0, n_min[i]});
        end
        o_q_job.absent[0] = (raw[0] == '0);
        o_q_job.absent[1] = (raw[2] == '0);
        o_q_job.low       = eff_low;
        o_q_job.high      = eff_high;
        o_q_job.mid       = mid_clip;
        o_q_job.rng       = rng_w[GW-1:0];
        o_q_job.fire      = ~i_in_data.button_bits[BL+3:BL];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= scjs_pkg::DEF_LOW;
            r_high <= scjs_pkg::DEF_HIGH;
            r_min  <= '1;
            r_max  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    scjs_pkg::CFG_RANGE_LOW:  r_low  <= $signed(i_cfg_wdata);
                    scjs_pkg::CFG_RANGE_HIGH: r_high <= $signed(i_cfg_wdata);
                    default: ;
                endcase
            end
            if (accept) begin
                r_min <= n_min;
                r_max <= n_max;
            end
        end
    end

    // once seeded, a maximum always sits above its minimum
    for (genvar g = 0; g < NAX; g++) begin : g_chk
        `SCJS_ASSERT_ALWAYS(a_max_above_min, i_clk, i_rst_n, (r_max[g] == '0) || (r_max[g] > {1'b0, r_min[g]}))
    end

endmodule

FILE: rtl/core/scjs_fifo.sv
// short job queue between front end and scaling unit
`include "assert_macros.svh"
module scjs_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  scjs_pkg::t_job i_push_job,
    output logic           o_full,
    input  logic           i_pop,
    output scjs_pkg::t_job o_pop_job,
    output logic           o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    scjs_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_pop_job = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `SCJS_ASSERT_ALWAYS(a_cnt_bounded, i_clk, i_rst_n, r_cnt <= CW'(DEPTH))
    `SCJS_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, i_push, !o_full || i_pop)

endmodule

FILE: rtl/core/scjs_div.sv
// restoring divider, one quotient bit per cycle
`include "assert_macros.svh"
module scjs_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  scjs_pkg::t_div_req i_req,
    output scjs_pkg::t_div_rsp o_rsp
);
    localparam int NW = scjs_pkg::NUM_W;
    localparam int QW = scjs_pkg::QUO_W;
    localparam int SW = scjs_pkg::SPAN_W;
    localparam int CN = scjs_pkg::DIV_CNT_W;

    logic [SW-1:0] r_rem;
    logic [QW-1:0] r_dvd;
    logic [SW-1:0] r_den;
    logic [CN-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [SW:0]   trial;
    logic [SW:0]   sub;
    logic          ge;

    assign trial = {r_rem, r_dvd[QW-1]};
    assign sub   = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CN'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CN'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // upper product bits start below the divisor since the quotient fits QW bits
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {{(SW - (NW - QW)){1'b0}}, i_req.num[NW-1:QW]};
            r_dvd <= i_req.num[QW-1:0];
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= ge ? sub[SW-1:0] : trial[SW-1:0];
            r_dvd <= {r_dvd[QW-2:0], ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_dvd;

    `SCJS_ASSERT_ALWAYS(a_cnt_range, i_clk, i_rst_n, r_cnt <= CN'(QW))

endmodule

FILE: rtl/core/scjs_be.sv
// back end: scales the four axes of a job in turn and holds the result
`include "assert_macros.svh"
module scjs_be (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  scjs_pkg::t_job     i_q_job,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    output scjs_pkg::t_div_req o_div_req,
    input  scjs_pkg::t_div_rsp i_div_rsp,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output scjs_pkg::t_out     o_out_data
);
    localparam int NW  = scjs_pkg::NUM_W;
    localparam int VW  = scjs_pkg::VAL_W;
    localparam int NAX = scjs_pkg::AXES;
    localparam int AXW = scjs_pkg::AX_W;

    scjs_pkg::t_be_state   r_state;
    scjs_pkg::t_be_state   n_state;
    scjs_pkg::t_job        r_job;
    logic [AXW-1:0]        r_ax;
    logic [NW-1:0]         r_prod;
    logic signed [VW-1:0]  r_val [NAX];
    logic                  r_out_valid;
    scjs_pkg::t_out        r_out;

    logic                  out_free;
    logic                  div_start;
    logic                  store_val;
    logic                  load_out;
    logic [NW-1:0]         prod_w;
    logic signed [VW+1:0]  sum_w;
    logic signed [VW+1:0]  high_ext;
    logic signed [VW-1:0]  val_w;

    assign out_free = !r_out_valid || !i_out_stall;
    assign prod_w   = r_job.diff[r_ax] * r_job.rng;

    always_comb begin
        sum_w    = {1'b0, i_div_rsp.quo} + {r_job.low[VW-1], r_job.low[VW-1], r_job.low};
        high_ext = {r_job.high[VW-1], r_job.high[VW-1], r_job.high};
        if (r_job.absent[r_ax[AXW-1]]) begin
            val_w = r_job.mid;
        end else if (r_job.bad[r_ax]) begin
            val_w = r_job.low;
        end else if (sum_w > high_ext) begin
            val_w = r_job.high;
        end else begin
            val_w = sum_w[VW-1:0];
        end
    end

    always_comb begin
        n_state   = r_state;
        o_q_pop   = 1'b0;
        div_start = 1'b0;
        store_val = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            scjs_pkg::BE_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = scjs_pkg::BE_MUL;
                end
            end
            scjs_pkg::BE_MUL: begin
                n_state = scjs_pkg::BE_START;
            end
            scjs_pkg::BE_START: begin
                div_start = 1'b1;
                n_state   = scjs_pkg::BE_DIV;
            end
            scjs_pkg::BE_DIV: begin
                if (i_div_rsp.done) begin
                    store_val = 1'b1;
                    n_state   = (r_ax == scjs_pkg::AX_LAST) ? scjs_pkg::BE_OUT
                                                            : scjs_pkg::BE_MUL;
                end
            end
            scjs_pkg::BE_OUT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = scjs_pkg::BE_IDLE;
                end
            end
            default: n_state = scjs_pkg::BE_IDLE;
        endcase
    end

    assign o_div_req.start = div_start;
    assign o_div_req.num   = r_prod;
    assign o_div_req.den   = r_job.span[r_ax];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= scjs_pkg::BE_IDLE;
            r_ax        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_q_pop) begin
                r_ax <= '0;
            end else if (store_val) begin
                r_ax <= r_ax + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_job;
        end
        if (r_state == scjs_pkg::BE_MUL) begin
            r_prod <= prod_w;
        end
        if (store_val) begin
            r_val[r_ax] <= val_w;
        end
        if (load_out) begin
            r_out.stick1_x      <= r_val[0];
            r_out.stick1_y      <= r_val[1];
            r_out.stick2_x      <= r_val[2];
            r_out.stick2_y      <= r_val[3];
            r_out.stick1_fire_a <= r_job.fire[0];
            r_out.stick1_fire_b <= r_job.fire[1];
            r_out.stick2_fire_a <= r_job.fire[2];
            r_out.stick2_fire_b <= r_job.fire[3];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SCJS_ASSERT_IMPLY(a_div_running, i_clk, i_rst_n, r_state == scjs_pkg::BE_DIV, i_div_rsp.busy || i_div_rsp.done)
    `SCJS_ASSERT_IMPLY(a_all_axes_done, i_clk, i_rst_n, load_out, r_ax == '0)

endmodule

FILE: rtl/core/self_calibrating_joystick_scaler.sv
// self-calibrating joystick scaler, top level
// path from accepted reading to result valid: queue, pop, then per axis multiply, start and divide, then load
// the back end scales one reading at a time through the shared 17-step divider used by all four axes
// the front end keeps taking readings while the queue has room; the result register waits for stall
// reset (synchronous, active low): range -1..1, minimums all ones, maximums zero, queue empty
module self_calibrating_joystick_scaler #(
    parameter int AXIS_BITS   = 16,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration writes, only while idle
    input  logic                           i_cfg_we,
    input  logic [scjs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [scjs_pkg::VAL_W-1:0]     i_cfg_wdata,
    // raw game-port readings
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  scjs_pkg::t_in                  i_in_data,
    // scaled axes and buttons
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output scjs_pkg::t_out                 o_out_data
);
    // front end to queue
    logic               q_push;
    logic               q_full;
    scjs_pkg::t_job     q_push_job;
    // queue to back end
    logic               q_pop;
    logic               q_empty;
    scjs_pkg::t_job     q_pop_job;
    // shared divider
    scjs_pkg::t_div_req div_req;
    scjs_pkg::t_div_rsp div_rsp;

    // calibration state lives here, so each job carries a snapshot
    // of min/max taken right after its own update
    scjs_fe #(
        .AXIS_BITS (AXIS_BITS)
    ) u_fe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_job     (q_push_job)
    );

    // decouples the front end, which pushes each job in the cycle its reading is accepted, from the slow scaling loop
    scjs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_job (q_push_job),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_pop_job  (q_pop_job),
        .o_empty    (q_empty)
    );

    // per axis: multiply (raw - min) by range, then divide by span
    scjs_be u_be (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_job     (q_pop_job),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // one divider serves all four axes
    scjs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule
